>>> rtl/schp_pkg.sv
`default_nettype none

package schp_pkg;

	localparam int PAYLOAD_DIGITS = 4;
	localparam int DIGIT_CNT_W    = 2;
	localparam int DELAY_W        = 16;
	localparam int NIBBLE_W       = 4;

	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_TWO    = 8'h32;
	localparam logic [7:0] CH_PLAY   = 8'h70;
	localparam logic [7:0] CH_STOP   = 8'h73;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_PERIOD = 8'h2e;
	localparam logic [7:0] CH_DELAY  = 8'h64;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_F   = 8'h66;

	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_TONE     = 3'd1,
		ACT_PLAY     = 3'd2,
		ACT_STOP     = 3'd3,
		ACT_OCT_DOWN = 3'd4,
		ACT_OCT_UP   = 3'd5,
		ACT_DELAY    = 3'd6
	} action_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       playing;
	} cmd_in_t;

	typedef struct packed {
		action_t              action;
		logic                 tone_index;
		logic [DELAY_W-1:0]   delay_value;
	} cmd_out_t;

endpackage

`default_nettype wire

>>> rtl/schp_if.sv
`default_nettype none

interface schp_in_if;
	logic              valid;
	logic              ready;
	schp_pkg::cmd_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface schp_out_if;
	logic               valid;
	logic               ready;
	schp_pkg::cmd_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/serial_command_hex_parser_core.sv
`default_nettype none
// channel | dir | payload                                  | transfer
// rx      | in  | rx_byte[7:0], playing                    | valid && ready
// res     | out | action[2:0], tone_index, delay_value[15:0] | valid && ready
//
// One byte per cycle unless res stalls; each byte gives one result, valid next cycle.
// Decode and parser state update sit between the state registers and the
// result register. arst_n resets the parser state and clears the result valid.
// rx.ready stays high while the result register is empty or being drained,
// so a stalled res side holds at most one result.

module serial_command_hex_parser_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	schp_in_if.sink         rx,
	schp_out_if.source      res
);

	logic                                  in_payload_q;
	logic [schp_pkg::DIGIT_CNT_W-1:0]      digit_count_q;
	logic [schp_pkg::DELAY_W-1:0]          accumulator_q;
	logic                                  payload_ok_q;
	logic                                  out_valid_q;
	schp_pkg::cmd_out_t                    out_data_q;

	logic                                  in_payload_n;
	logic [schp_pkg::DIGIT_CNT_W-1:0]      digit_count_n;
	logic [schp_pkg::DELAY_W-1:0]          accumulator_n;
	logic                                  payload_ok_n;
	schp_pkg::cmd_out_t                    result;
	logic                                  is_hex;
	logic [schp_pkg::NIBBLE_W-1:0]         nibble;
	logic                                  take;
	logic [7:0]                            b;

	assign rx.ready  = !out_valid_q || res.ready;
	assign take      = rx.valid && rx.ready;
	assign res.valid = out_valid_q;
	assign res.data  = out_data_q;
	assign b         = rx.data.rx_byte;

	always_comb begin
		is_hex = 1'b0;
		nibble = '0;
		if (b >= schp_pkg::CH_ZERO && b <= schp_pkg::CH_NINE) begin
			is_hex = 1'b1;
			nibble = schp_pkg::NIBBLE_W'(b - schp_pkg::CH_ZERO);
		end else if (b >= schp_pkg::CH_LC_A && b <= schp_pkg::CH_LC_F) begin
			is_hex = 1'b1;
			nibble = schp_pkg::NIBBLE_W'(b - schp_pkg::CH_LC_A + 8'd10);
		end
	end

	always_comb begin
		in_payload_n       = in_payload_q;
		digit_count_n      = digit_count_q;
		accumulator_n      = accumulator_q;
		payload_ok_n       = payload_ok_q;
		result.action      = schp_pkg::ACT_NONE;
		result.tone_index  = 1'b0;
		result.delay_value = '0;
		if (!in_payload_q) begin
			case (b)
				schp_pkg::CH_ONE: begin
					result.action = schp_pkg::ACT_TONE;
				end
				schp_pkg::CH_TWO: begin
					result.action     = schp_pkg::ACT_TONE;
					result.tone_index = 1'b1;
				end
				schp_pkg::CH_PLAY: begin
					if (!rx.data.playing) result.action = schp_pkg::ACT_PLAY;
				end
				schp_pkg::CH_STOP: begin
					if (rx.data.playing) result.action = schp_pkg::ACT_STOP;
				end
				schp_pkg::CH_COMMA: begin
					result.action = schp_pkg::ACT_OCT_DOWN;
				end
				schp_pkg::CH_PERIOD: begin
					result.action = schp_pkg::ACT_OCT_UP;
				end
				schp_pkg::CH_DELAY: begin
					payload_ok_n  = 1'b1;
					digit_count_n = '0;
					accumulator_n = '0;
					in_payload_n  = 1'b1;
				end
				default: begin
				end
			endcase
		end else begin
			if (is_hex) begin
				accumulator_n = {accumulator_q[schp_pkg::DELAY_W-schp_pkg::NIBBLE_W-1:0],
					nibble};
			end else begin
				payload_ok_n = 1'b0;
			end
			if (digit_count_q ==
				schp_pkg::DIGIT_CNT_W'(schp_pkg::PAYLOAD_DIGITS - 1)) begin
				if (payload_ok_n) begin
					result.action      = schp_pkg::ACT_DELAY;
					result.delay_value = accumulator_n;
				end
				in_payload_n  = 1'b0;
				digit_count_n = '0;
			end else begin
				digit_count_n = digit_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q  <= 1'b0;
			digit_count_q <= '0;
			accumulator_q <= '0;
			payload_ok_q  <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				in_payload_q  <= in_payload_n;
				digit_count_q <= digit_count_n;
				accumulator_q <= accumulator_n;
				payload_ok_q  <= payload_ok_n;
				out_valid_q   <= 1'b1;
			end else if (res.ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= result;
		end
	end

endmodule

`default_nettype wire

>>> tb/tb_serial_command_hex_parser_core.sv
`timescale 1ns / 100ps

module tb_serial_command_hex_parser_core;

	localparam logic FIXED     = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef struct packed {
		logic [7:0]                   rx_byte;
		logic                         playing;
		logic                         fixed;
		schp_pkg::action_t            act;
		logic                         tone;
		logic [schp_pkg::DELAY_W-1:0] delay;
	} stim_row_t;

	localparam stim_row_t DIRECTED [25] = '{
		'{8'h00,               1'b0, FIXED,     schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{8'hff,               1'b1, FIXED,     schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_ONE,    1'b0, FIXED,     schp_pkg::ACT_TONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_TWO,    1'b1, FIXED,     schp_pkg::ACT_TONE,     1'b1, 16'h0000},
		'{schp_pkg::CH_PLAY,   1'b0, FIXED,     schp_pkg::ACT_PLAY,     1'b0, 16'h0000},
		'{schp_pkg::CH_PLAY,   1'b1, FIXED,     schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_STOP,   1'b1, FIXED,     schp_pkg::ACT_STOP,     1'b0, 16'h0000},
		'{schp_pkg::CH_STOP,   1'b0, FIXED,     schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_COMMA,  1'b1, FIXED,     schp_pkg::ACT_OCT_DOWN, 1'b0, 16'h0000},
		'{schp_pkg::CH_PERIOD, 1'b0, FIXED,     schp_pkg::ACT_OCT_UP,   1'b0, 16'h0000},
		'{schp_pkg::CH_DELAY,  1'b0, FIXED,     schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_LC_F,   1'b1, FIXED,     schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_LC_F,   1'b0, FIXED,     schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_LC_F,   1'b1, FIXED,     schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_LC_F,   1'b0, FIXED,     schp_pkg::ACT_DELAY,    1'b0, 16'hffff},
		'{schp_pkg::CH_DELAY,  1'b1, FIXED,     schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_ZERO,   1'b0, FIXED,     schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_NINE,   1'b1, PREDICTED, schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_LC_A,   1'b0, PREDICTED, schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_ZERO,   1'b1, PREDICTED, schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_DELAY,  1'b0, FIXED,     schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{8'h41,               1'b1, PREDICTED, schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{8'h2f,               1'b0, PREDICTED, schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{8'h67,               1'b1, PREDICTED, schp_pkg::ACT_NONE,     1'b0, 16'h0000},
		'{schp_pkg::CH_DELAY,  1'b0, FIXED,     schp_pkg::ACT_NONE,     1'b0, 16'h0000}
	};

	localparam logic [7:0] COMMANDS [6] = '{schp_pkg::CH_ONE, schp_pkg::CH_TWO,
		schp_pkg::CH_PLAY, schp_pkg::CH_STOP, schp_pkg::CH_COMMA, schp_pkg::CH_PERIOD};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	schp_in_if  rx_ch ();
	schp_out_if res_ch ();

	serial_command_hex_parser_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	logic                             in_payload;
	logic [schp_pkg::DIGIT_CNT_W-1:0] digit_cnt;
	logic [schp_pkg::DELAY_W-1:0]     acc;
	logic                             payload_ok;

	schp_pkg::cmd_out_t pending_actions [$];
	int bytes_sent;
	int results_checked;
	int delays_seen;
	int mismatches;

	always #2 clk = ~clk;

	function automatic schp_pkg::cmd_out_t decode_byte(input logic [7:0] b, input logic play);
		schp_pkg::cmd_out_t r;
		logic [schp_pkg::NIBBLE_W-1:0] nib;
		logic hex_ok;
		int taken;
		r = '{action: schp_pkg::ACT_NONE, tone_index: 1'b0, delay_value: '0};
		if (!in_payload) begin
			case (b)
				schp_pkg::CH_ONE, schp_pkg::CH_TWO: begin
					r.action = schp_pkg::ACT_TONE;
					r.tone_index = (b == schp_pkg::CH_TWO);
				end
				schp_pkg::CH_PLAY: if (!play) r.action = schp_pkg::ACT_PLAY;
				schp_pkg::CH_STOP: if (play) r.action = schp_pkg::ACT_STOP;
				schp_pkg::CH_COMMA: r.action = schp_pkg::ACT_OCT_DOWN;
				schp_pkg::CH_PERIOD: r.action = schp_pkg::ACT_OCT_UP;
				schp_pkg::CH_DELAY: begin
					payload_ok = 1'b1;
					digit_cnt = '0;
					acc = '0;
					in_payload = 1'b1;
				end
				default: ;
			endcase
		end else begin
			hex_ok = 1'b1;
			nib = '0;
			if (b >= schp_pkg::CH_ZERO && b <= schp_pkg::CH_NINE)
				nib = schp_pkg::NIBBLE_W'(b - schp_pkg::CH_ZERO);
			else if (b >= schp_pkg::CH_LC_A && b <= schp_pkg::CH_LC_F)
				nib = schp_pkg::NIBBLE_W'(b - schp_pkg::CH_LC_A + 8'd10);
			else
				hex_ok = 1'b0;
			if (hex_ok)
				acc = {acc[schp_pkg::DELAY_W-schp_pkg::NIBBLE_W-1:0], nib};
			else
				payload_ok = 1'b0;
			taken = int'(digit_cnt) + 1;
			if (taken >= schp_pkg::PAYLOAD_DIGITS) begin
				if (payload_ok) begin
					r.action = schp_pkg::ACT_DELAY;
					r.delay_value = acc;
				end
				in_payload = 1'b0;
				digit_cnt = '0;
			end else begin
				digit_cnt = schp_pkg::DIGIT_CNT_W'(taken);
			end
		end
		return r;
	endfunction

	function automatic stim_row_t stim(input logic [7:0] b);
		stim_row_t r;
		r = '0;
		r.rx_byte = b;
		r.playing = 1'($urandom_range(0, 1));
		r.fixed = PREDICTED;
		r.act = schp_pkg::ACT_NONE;
		return r;
	endfunction

	function automatic logic [7:0] payload_char();
		int v;
		if ($urandom_range(0, 9) != 0) begin
			v = $urandom_range(0, 15);
			return (v < 10) ? schp_pkg::CH_ZERO + 8'(v) : schp_pkg::CH_LC_A + 8'(v - 10);
		end
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(8'h41, 8'h46));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns: mismatch on result %0d: %s", $time, results_checked, what);
	endtask

	task automatic offer(input stim_row_t r);
		int gap;
		schp_pkg::cmd_out_t want;
		gap = ((bytes_sent / 60) % 4 == 3) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.data <= {r.rx_byte, r.playing};
		do @(posedge clk); while (!rx_ch.ready);
		want = decode_byte(r.rx_byte, r.playing);
		if (r.fixed)
			want = '{action: r.act, tone_index: r.tone, delay_value: r.delay};
		pending_actions.push_back(want);
		bytes_sent++;
	endtask

	always @(posedge clk) begin
		schp_pkg::cmd_out_t got;
		schp_pkg::cmd_out_t want;
		if (res_ch.valid && res_ch.ready) begin
			got = res_ch.data;
			if (pending_actions.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer, action %0d", got.action));
			end else begin
				want = pending_actions.pop_front();
				if (got.action !== want.action)
					report_mismatch($sformatf("action %0d, expected %0d",
						got.action, want.action));
				if (got.tone_index !== want.tone_index)
					report_mismatch($sformatf("tone_index %0b, expected %0b",
						got.tone_index, want.tone_index));
				if (got.delay_value !== want.delay_value)
					report_mismatch($sformatf("delay_value %h, expected %h",
						got.delay_value, want.delay_value));
			end
			if (got.action == schp_pkg::ACT_DELAY)
				delays_seen++;
			results_checked++;
		end
	end

	initial begin
		int hold;
		int drained;
		drained = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// hold off long enough for the input side to stall
			if (drained == 300 || drained == 620)
				hold = 250;
			else
				hold = ((drained / 40) % 3 == 2) ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			drained++;
		end
	end

	initial begin
		int pick;
		rx_ch.valid <= 1'b0;
		rx_ch.data <= '0;
		in_payload = 1'b0;
		digit_cnt = '0;
		acc = '0;
		payload_ok = 1'b1;
		bytes_sent = 0;
		results_checked = 0;
		delays_seen = 0;
		mismatches = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			offer(DIRECTED[i]);

		while (bytes_sent < 850) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				offer(stim(schp_pkg::CH_DELAY));
				repeat (schp_pkg::PAYLOAD_DIGITS) offer(stim(payload_char()));
			end else if (pick < 85) begin
				offer(stim(COMMANDS[$urandom_range(0, 5)]));
			end else begin
				offer(stim(8'($urandom_range(0, 255))));
			end
		end
		rx_ch.valid <= 1'b0;

		while (pending_actions.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d bytes (%0d directed), %0d results checked, %0d delay updates",
			bytes_sent, $size(DIRECTED), results_checked, delays_seen);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0)
			$display("tb_serial_command_hex_parser_core passed");
		else
			$display("tb_serial_command_hex_parser_core failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results pending", pending_actions.size());
		$display("tb_serial_command_hex_parser_core failed");
		$finish;
	end

endmodule
